FILE: rtl/psr_pkg.sv
// Shared types and constants for the polyphase resampler.
// No dependencies; used by psr_mac and polyphase_sinc_resampler.
package psr_pkg;

   localparam int TAP_COUNT_DEF   = 32;
   localparam int PHASE_COUNT_DEF = 256;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic REG_RATE_STEP = 1'b0;
   localparam logic REG_BYPASS    = 1'b1;

   localparam logic [31:0] RATE_STEP_RESET = 32'd16777216;
   localparam logic [31:0] MIN_STEP        = 32'd262144;
   localparam logic [6:0]  MAX_RESULTS     = 7'd64;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_RUN  = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic clr;
      logic issue;
   } mac_ctl_type;

endpackage

FILE: rtl/psr_cell.sv
// One history cell of the sample chain: holds a sample, takes its neighbor's.
// Depends on nothing.
module psr_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               clr,
   input  logic               en,
   input  logic signed [15:0] d,
   output logic signed [15:0] q
);
   logic signed [15:0] data_ff;
   logic signed [15:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (clr) begin
         data_in = '0;
      end else if (en) begin
         data_in = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;
endmodule

FILE: rtl/psr_mac.sv
// Coefficient store and pipelined interpolating multiply-accumulate unit.
// Depends on psr_pkg.
module psr_mac #(
   parameter int TAP_COUNT   = psr_pkg::TAP_COUNT_DEF,
   parameter int PHASE_COUNT = psr_pkg::PHASE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  psr_pkg::mac_ctl_type                ctl,
   input  logic [$clog2(PHASE_COUNT)-1:0]      row,
   input  logic [15:0]                         f16,
   input  logic [$clog2(TAP_COUNT)-1:0]        tap,
   input  logic signed [15:0]                  sample,
   input  logic                                coef_we,
   input  logic [13:0]                         coef_index,
   input  logic signed [17:0]                  coef_value,
   output logic signed [15:0]                  result,
   output logic                                busy
);
   import psr_pkg::*;

   localparam int DEPTH  = (PHASE_COUNT + 1) * TAP_COUNT;
   localparam int AW     = $clog2(DEPTH);
   localparam int ACC_W  = 53 + $clog2(TAP_COUNT) + 1;
   localparam int R_W    = ACC_W - 32;

   logic signed [17:0] mem [DEPTH];

   logic [31:0]        base_lo;
   logic [31:0]        addr_lo32;
   logic [31:0]        addr_hi32;
   logic [31:0]        wr32;
   logic               wr_ok;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [17:0] lo_ff, hi_ff, lo2_ff;
   logic signed [15:0] s1_ff, s2_ff, s3_ff;
   logic signed [35:0] prod_ff;
   logic signed [36:0] w_ff;
   logic signed [52:0] sw_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   logic signed [18:0] diff;
   logic signed [35:0] prod_in;
   logic signed [36:0] w_in;
   logic signed [52:0] sw_in;

   logic               neg;
   logic [ACC_W-1:0]   mag;
   logic [ACC_W-1:0]   rnd;
   logic [R_W-1:0]     r;

   assign base_lo   = 32'(row) * 32'(TAP_COUNT);
   assign addr_lo32 = base_lo + 32'(tap);
   assign addr_hi32 = addr_lo32 + 32'(TAP_COUNT);
   assign wr32      = 32'(coef_index);
   assign wr_ok     = coef_we && (wr32 < 32'(DEPTH));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr32[AW-1:0]] <= coef_value;
      end
      if (ctl.issue) begin
         lo_ff <= mem[addr_lo32[AW-1:0]];
         hi_ff <= mem[addr_hi32[AW-1:0]];
      end
   end

   assign diff    = 19'(hi_ff) - 19'(lo_ff);
   assign prod_in = 36'(diff) * 36'($signed({1'b0, f16}));
   assign w_in    = $signed({lo2_ff, 16'b0}) + 37'(prod_ff);
   assign sw_in   = s3_ff * w_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clr) begin
         acc_in = '0;
      end else if (v4_ff) begin
         acc_in = acc_ff + ACC_W'(sw_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= sample;
      s2_ff   <= s1_ff;
      prod_ff <= prod_in;
      lo2_ff  <= lo_ff;
      s3_ff   <= s2_ff;
      w_ff    <= w_in;
      sw_ff   <= sw_in;
      acc_ff  <= acc_in;
   end

   assign busy = v1_ff | v2_ff | v3_ff | v4_ff;

   // round half away from zero, then saturate
   assign neg = acc_ff[ACC_W-1];
   assign mag = neg ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign rnd = mag + ACC_W'(64'h8000_0000);
   assign r   = rnd[ACC_W-1:32];

   always_comb begin
      if (neg) begin
         if (r > R_W'(32768)) begin
            result = -16'sd32768;
         end else begin
            result = $signed(16'(-r));
         end
      end else begin
         if (r > R_W'(32767)) begin
            result = 16'sd32767;
         end else begin
            result = $signed(r[15:0]);
         end
      end
   end
endmodule

FILE: rtl/polyphase_sinc_resampler.sv
// Polyphase resampler: each filtered result passes a setup state, then the taps run
// one per cycle through the shared multiply-accumulate unit and its coefficient memory
// read port, then the wait state drains the pipeline and the output state hands it off;
// an input sample yields 0..64 results, and a new request is taken only in idle.
// Load, clear, bypassed samples and samples without results finish in the idle state.
// A result held back by rsp_tready stalls the output state.
// The history is a chain of cells that rotates once around per result.
// Depends on psr_pkg, psr_cell and psr_mac.
module polyphase_sinc_resampler #(
   parameter int TAP_COUNT   = psr_pkg::TAP_COUNT_DEF,
   parameter int PHASE_COUNT = psr_pkg::PHASE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sample_in[15:0], coef_index[29:16], coef_value[47:30]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sample_out[15:0]
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import psr_pkg::*;

   localparam int TW = $clog2(TAP_COUNT);
   localparam int RW = $clog2(PHASE_COUNT);
   localparam logic signed [9:0] EMIT_AT = 10'(TAP_COUNT / 2 + 1);

   state_type          state_ff, state_in;
   logic [31:0]        rate_ff;
   logic               bypass_ff;
   logic [23:0]        frac_ff, frac_in;
   logic signed [9:0]  ahead_ff, ahead_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [TW-1:0]      tap_ff, tap_in;
   logic [RW-1:0]      row_ff;
   logic [15:0]        f16_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               xfer;
   logic               out_free;
   logic [1:0]         cmd;
   logic signed [15:0] sample_in;
   logic               push, rotate, clr;
   logic signed [15:0] cell_q [TAP_COUNT];
   logic signed [15:0] head;
   logic [35:0]        pos;
   logic [11:0]        row_raw;
   logic [31:0]        step;
   logic [32:0]        sum;
   logic signed [9:0]  ahead_next;
   logic               more;
   logic signed [9:0]  ahead_inc;
   mac_ctl_type        mac_ctl;
   logic signed [15:0] result;
   logic               mac_busy;

   assign cmd       = req_tuser;
   assign sample_in = $signed(req_tdata[15:0]);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign xfer      = req_tvalid && req_tready;

   assign push   = xfer && (cmd == CMD_SAMPLE) && !bypass_ff;
   assign clr    = xfer && (cmd == CMD_CLEAR);
   assign rotate = (state_ff == ST_RUN);
   assign head   = cell_q[TAP_COUNT-1];

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_chain
      logic signed [15:0] d;
      if (k == 0) begin : g_first
         assign d = rotate ? head : sample_in;
      end else begin : g_rest
         assign d = cell_q[k-1];
      end
      psr_cell u_cell (
         .clock (clock),
         .reset (reset),
         .clr   (clr),
         .en    (push || rotate),
         .d     (d),
         .q     (cell_q[k])
      );
   end

   assign mac_ctl.clr   = (state_ff == ST_PREP);
   assign mac_ctl.issue = (state_ff == ST_RUN);

   psr_mac #(
      .TAP_COUNT   (TAP_COUNT),
      .PHASE_COUNT (PHASE_COUNT)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .row        (row_ff),
      .f16        (f16_ff),
      .tap        (tap_ff),
      .sample     (head),
      .coef_we    (xfer && (cmd == CMD_LOAD)),
      .coef_index (req_tdata[29:16]),
      .coef_value ($signed(req_tdata[47:30])),
      .result     (result),
      .busy       (mac_busy)
   );

   assign pos     = 36'(frac_ff) * 36'(PHASE_COUNT);
   assign row_raw = pos[35:24];
   assign step    = (rate_ff < MIN_STEP) ? MIN_STEP : rate_ff;
   assign sum     = {9'b0, frac_ff} + {1'b0, step};
   assign ahead_next = ahead_ff - $signed({1'b0, sum[32:24]});
   assign more    = (ahead_next >= EMIT_AT) && ((cnt_ff + 7'd1) < MAX_RESULTS);
   assign ahead_inc = ahead_ff + 10'sd1;

   always_comb begin
      state_in     = state_ff;
      frac_in      = frac_ff;
      ahead_in     = ahead_ff;
      cnt_in       = cnt_ff;
      tap_in       = tap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (xfer && (cmd == CMD_SAMPLE)) begin
               if (bypass_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = req_tdata[15:0];
                  rsp_last_in  = 1'b1;
               end else begin
                  ahead_in = ahead_inc;
                  cnt_in   = '0;
                  if (ahead_inc >= EMIT_AT) begin
                     state_in = ST_PREP;
                  end
               end
            end else if (clr) begin
               frac_in  = '0;
               ahead_in = '0;
            end
         end
         ST_PREP: begin
            tap_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            tap_in = tap_ff + TW'(1);
            if (tap_ff == TW'(TAP_COUNT - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!mac_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               rsp_last_in  = !more;
               frac_in      = sum[23:0];
               ahead_in     = ahead_next;
               cnt_in       = cnt_ff + 7'd1;
               state_in     = more ? ST_PREP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_STEP_RESET;
         bypass_ff    <= 1'b1;
         frac_ff      <= '0;
         ahead_ff     <= '0;
         cnt_ff       <= '0;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frac_ff      <= frac_in;
         ahead_ff     <= ahead_in;
         cnt_ff       <= cnt_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen && (csr_index == REG_RATE_STEP)) begin
            rate_ff <= csr_wdata;
         end
         if (csr_wen && (csr_index == REG_BYPASS)) begin
            bypass_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ST_PREP || state_ff == ST_IDLE) begin
         row_ff <= (row_raw >= 12'(PHASE_COUNT)) ? RW'(PHASE_COUNT - 1) : row_raw[RW-1:0];
         f16_ff <= pos[23:8];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      xfer |-> state_ff == ST_IDLE)
      else $error("input transfer outside idle");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_RESULTS)
      else $error("result count past limit");
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> tap_ff <= TW'(TAP_COUNT - 1))
      else $error("tap counter out of range");
   a_out_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> !mac_busy)
      else $error("result taken before pipeline drained");
`endif
endmodule
